>>> hdl/otr_pkg.sv
// package with payload types, codes and the control program of the trace ring
package otr_pkg;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TAIL  = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic [6:0] tail_limit;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last;
    logic        empty_res;
    logic [31:0] total_count;
  } rsp_t;

  typedef logic [2:0] step_t;

  localparam step_t ST_IDLE     = 3'd0;
  localparam step_t ST_SCAN_RD  = 3'd1;
  localparam step_t ST_SCAN_CHK = 3'd2;
  localparam step_t ST_EMIT_RD  = 3'd3;
  localparam step_t ST_EMIT_OUT = 3'd4;
  localparam step_t ST_EMPTY    = 3'd5;

  typedef enum logic [1:0] {
    C_NEXT,
    C_DISPATCH,
    C_SCAN,
    C_OUT
  } cond_t;

  typedef struct packed {
    logic  take;
    logic  rd;
    logic  chk;
    logic  emit;
    logic  empty;
    cond_t cond;
    step_t next_step;
    step_t jump_step;
  } cw_t;

  function automatic cw_t ucode(input step_t s);
    cw_t w;
    w = '{take: 1'b0, rd: 1'b0, chk: 1'b0, emit: 1'b0, empty: 1'b0,
          cond: C_NEXT, next_step: ST_IDLE, jump_step: ST_IDLE};
    unique case (s)
      ST_IDLE: begin
        w.take      = 1'b1;
        w.cond      = C_DISPATCH;
        w.next_step = ST_EMIT_RD;
        w.jump_step = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        w.rd        = 1'b1;
        w.next_step = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        w.chk       = 1'b1;
        w.cond      = C_SCAN;
        w.next_step = ST_SCAN_RD;
        w.jump_step = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        w.rd        = 1'b1;
        w.next_step = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        w.emit      = 1'b1;
        w.cond      = C_OUT;
        w.next_step = ST_EMIT_RD;
        w.jump_step = ST_IDLE;
      end
      ST_EMPTY: begin
        w.empty     = 1'b1;
        w.cond      = C_OUT;
        w.next_step = ST_IDLE;
        w.jump_step = ST_IDLE;
      end
      default: begin
        w.next_step = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> hdl/overwriting_trace_ring_with_tail.sv
// Byte trace ring that overwrites its oldest bytes and plays back its newest
// bytes on request. A write transaction stores one byte. A tail transaction
// is run by a small control program over the single-port ring memory, whose
// read data is registered: at most one memory access per program step. When
// the request is cut to its full limit the window is first scanned for a
// newline with a read and a check step per byte scanned, then every delivered
// byte takes a read and an output step, the output step held while the result
// side stalls; an empty view takes one empty step. No new transaction is taken
// until the last result of a tail has been loaded into the output register.
module overwriting_trace_ring_with_tail #(
  parameter int RING_DEPTH = 1024,
  parameter int MAX_TAIL   = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  otr_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output otr_pkg::rsp_t rsp
);
  import otr_pkg::*;

  localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(MAX_TAIL + 1);
  localparam int SW = PW + CW + 1;
  localparam logic [PW-1:0] LAST_SLOT = PW'(RING_DEPTH - 1);

  logic [7:0]    mem [RING_DEPTH];

  step_t         step;
  step_t         step_next;
  cw_t           cw;
  logic [PW-1:0] head;
  logic [31:0]   count;
  logic [CW-1:0] n;
  logic [CW-1:0] idx;
  logic [PW-1:0] ptr;
  logic [PW-1:0] start_ptr;
  logic [31:0]   tail_total;
  logic [7:0]    rd_data;

  logic          take_write;
  logic          take_tail;
  logic [CW-1:0] limit_c;
  logic [31:0]   min_a;
  logic [31:0]   min_b;
  logic [CW-1:0] n_calc;
  logic [PW-1:0] start_calc;
  logic [SW-1:0] head_w;
  logic [SW-1:0] n_w;
  logic [PW-1:0] ptr_inc;
  logic [PW-1:0] head_inc;
  logic [CW-1:0] idx_inc;
  logic          idx_last;
  logic          is_nl;
  logic          scan_done;
  logic          out_free;
  logic          out_load;
  logic          out_last;

  assign cw        = ucode(step);
  assign cmd_stall = !cw.take;
  assign take_write = cmd_valid && cw.take && (cmd.func == FUNC_WRITE);
  assign take_tail  = cmd_valid && cw.take && (cmd.func == FUNC_TAIL);

  // request size
  always_comb begin
    if (32'(cmd.tail_limit) > 32'(MAX_TAIL)) begin
      limit_c = CW'(MAX_TAIL);
    end else begin
      limit_c = CW'(cmd.tail_limit);
    end
    min_a  = (count < 32'(RING_DEPTH)) ? count : 32'(RING_DEPTH);
    min_b  = (min_a < 32'(limit_c)) ? min_a : 32'(limit_c);
    n_calc = CW'(min_b);
    head_w = SW'(head);
    n_w    = SW'(n_calc);
    if (head_w >= n_w) begin
      start_calc = PW'(head_w - n_w);
    end else begin
      start_calc = PW'(head_w + SW'(RING_DEPTH) - n_w);
    end
  end

  assign ptr_inc   = (ptr == LAST_SLOT) ? '0 : ptr + PW'(1);
  assign head_inc  = (head == LAST_SLOT) ? '0 : head + PW'(1);
  assign idx_inc   = idx + CW'(1);
  assign idx_last  = ({1'b0, idx} + (CW+1)'(1)) == {1'b0, n};
  assign is_nl     = (rd_data == NEWLINE_CODE);
  assign scan_done = is_nl || idx_last;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign out_load  = (cw.emit || cw.empty) && out_free;
  assign out_last  = cw.empty || idx_last;

  // step sequencing
  always_comb begin
    step_next = step;
    unique case (cw.cond)
      C_NEXT: begin
        step_next = cw.next_step;
      end
      C_DISPATCH: begin
        if (take_tail) begin
          if (n_calc == '0) begin
            step_next = ST_EMPTY;
          end else if (n_calc == limit_c) begin
            step_next = cw.jump_step;
          end else begin
            step_next = cw.next_step;
          end
        end
      end
      C_SCAN: begin
        step_next = scan_done ? cw.jump_step : cw.next_step;
      end
      C_OUT: begin
        if (out_free) begin
          step_next = out_last ? cw.jump_step : cw.next_step;
        end
      end
      default: begin
        step_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (take_write) begin
        head <= head_inc;
        if (count != '1) begin
          count <= count + 32'd1;
        end
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (take_tail) begin
      n          <= n_calc;
      ptr        <= start_calc;
      start_ptr  <= start_calc;
      idx        <= '0;
      tail_total <= count;
    end else if (cw.chk) begin
      if (!scan_done || (is_nl && !idx_last)) begin
        ptr <= ptr_inc;
        idx <= idx_inc;
      end else begin
        ptr <= start_ptr;
        idx <= '0;
      end
    end else if (cw.emit && out_free) begin
      ptr <= ptr_inc;
      idx <= idx_inc;
    end
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (take_write) begin
      mem[head] <= cmd.data_byte;
    end
    if (cw.rd) begin
      rd_data <= mem[ptr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.out_byte    <= cw.empty ? 8'd0 : rd_data;
      rsp.last        <= out_last;
      rsp.empty_res   <= cw.empty;
      rsp.total_count <= tail_total;
    end
  end

endmodule
